[design/tle_pkg.sv]
// Package with shared constants and types for the line ending converter.
`timescale 1ns / 1ps

package tle_pkg;

    // Character codes used by the conversion rules.
    localparam logic [7:0] ChUnder = 8'h5F;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChCtrlZ = 8'h1A;

    // One input byte yields at most this many output bytes.
    localparam int MaxRes = 3;

    // Queue between the classifier and the serializer.
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Configuration register map.
    localparam int ApbAddrW = 3;
    localparam logic RegDirection    = 1'b0;
    localparam logic RegTransferMode = 1'b1;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_UNDER,
        PEND_CR,
        PEND_LF
    } pend_t;

    typedef enum logic {
        DIR_UNIX_TO_DISK,
        DIR_DISK_TO_UNIX
    } dir_t;

    typedef enum logic {
        MODE_ASCII,
        MODE_BINARY
    } mode_t;

    // A group of output bytes produced by one input transaction.
    typedef struct packed {
        logic [MaxRes-1:0][7:0] data;
        logic [1:0]             cnt;
    } run_t;

    // Settings and the clear strobe handed to the classifier.
    typedef struct packed {
        dir_t  direction;
        mode_t transfer_mode;
        logic  clear;
    } cfg_t;

endpackage

[design/tle_in_if.sv]
// Input channel interface: source bytes with an end marker.
`timescale 1ns / 1ps

interface tle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

[design/tle_out_if.sv]
// Output channel interface: converted bytes with a run marker.
`timescale 1ns / 1ps

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[design/text_line_ending_converter.sv]
// Top level of the line ending converter: register port, classifier, queue and serializer.
//
//   channel  direction  payload                       handshake
//   in_ch    sink       in_byte[8], end_of_input[1]   valid / ready
//   out_ch   source     out_byte[8], last_of_run[1]   valid / ready
//   apb      slave      direction@0x0, mode@0x4       psel / penable, pready tied high
//
// An input transaction is taken whenever the four-entry run queue has room.
// Each transaction yields zero to three output bytes; the serializer sends one byte per
// cycle while out_ch.ready is high, and new input is taken while earlier runs still drain.
// Reset clears the held character, the end flag, the queue and the serializer.
// A stalled output fills the queue and then drops in_ch.ready; nothing is lost.
`timescale 1ns / 1ps

module text_line_ending_converter
    import tle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tle_in_if.sink              in_ch,
    tle_out_if.source           out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    dir_t  dir_reg;
    mode_t mode_reg;
    logic  cfg_wr;
    logic  reg_sel;
    cfg_t  cfg;
    run_t  run;
    logic  run_valid;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    run_t  head;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= DIR_UNIX_TO_DISK;
            mode_reg <= MODE_ASCII;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                RegDirection:    dir_reg  <= dir_t'(pwdata[0]);
                RegTransferMode: mode_reg <= mode_t'(pwdata[0]);
                default:         dir_reg  <= dir_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            RegDirection:    prdata = {31'd0, dir_reg};
            RegTransferMode: prdata = {31'd0, mode_reg};
            default:         prdata = '0;
        endcase
    end

    // Any register write discards a held character and the end-of-text flag.
    assign cfg.direction     = dir_reg;
    assign cfg.transfer_mode = mode_reg;
    assign cfg.clear         = cfg_wr;

    tle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .run       (run),
        .run_valid (run_valid),
        .run_ready (!q_full)
    );

    tle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (run_valid),
        .push_run (run),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    tle_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

[design/tle_front.sv]
// Classifier: accepts source bytes, tracks the held character and builds output runs.
`timescale 1ns / 1ps

module tle_front
    import tle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tle_in_if.sink   in_ch,
    input  cfg_t     cfg,
    output run_t     run,
    output logic     run_valid,
    input  logic     run_ready
);

    pend_t pend_reg, pend_next;
    logic  fin_reg, fin_next;
    logic  fire;
    run_t  run_calc;

    function automatic run_t push_byte(run_t r, logic [7:0] b);
        run_t t;
        t = r;
        t.data[t.cnt] = b;
        t.cnt = t.cnt + 2'd1;
        return t;
    endfunction

    assign in_ch.ready = run_ready;
    assign fire        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [7:0] c;
        c         = in_ch.in_byte;
        run_calc  = '0;
        pend_next = pend_reg;
        fin_next  = fin_reg;
        if (cfg.transfer_mode == MODE_BINARY)
        begin
            pend_next = PEND_NONE;
            fin_next  = 1'b0;
            if (!in_ch.end_of_input)
            begin
                run_calc = push_byte(run_calc, c);
            end
        end
        else if (cfg.direction == DIR_UNIX_TO_DISK)
        begin
            fin_next  = 1'b0;
            pend_next = PEND_NONE;
            if (in_ch.end_of_input)
            begin
                if (pend_reg == PEND_UNDER)
                begin
                    run_calc = push_byte(run_calc, ChUnder);
                end
                run_calc = push_byte(run_calc, ChCtrlZ);
            end
            else if (pend_reg == PEND_UNDER && c == ChLf)
            begin
                run_calc = push_byte(run_calc, ChLf);
                run_calc = push_byte(run_calc, ChCr);
                run_calc = push_byte(run_calc, ChNul);
            end
            else
            begin
                // A held underscore not followed by LF goes out as is.
                if (pend_reg == PEND_UNDER)
                begin
                    run_calc = push_byte(run_calc, ChUnder);
                end
                if (c == ChUnder)
                begin
                    pend_next = PEND_UNDER;
                end
                else if (c == ChLf)
                begin
                    run_calc = push_byte(run_calc, ChCr);
                    run_calc = push_byte(run_calc, ChLf);
                end
                else
                begin
                    run_calc = push_byte(run_calc, c);
                end
            end
        end
        else
        begin
            if (in_ch.end_of_input)
            begin
                if (pend_reg == PEND_CR)
                begin
                    run_calc = push_byte(run_calc, ChCr);
                end
                else if (pend_reg == PEND_LF)
                begin
                    run_calc = push_byte(run_calc, ChLf);
                end
                pend_next = PEND_NONE;
                fin_next  = 1'b0;
            end
            else if (!fin_reg)
            begin
                pend_next = PEND_NONE;
                case (pend_reg)
                    PEND_CR:
                    begin
                        if (c == ChLf)
                        begin
                            run_calc = push_byte(run_calc, ChLf);
                        end
                        else
                        begin
                            run_calc = push_byte(run_calc, ChCr);
                            run_calc = push_byte(run_calc, c);
                        end
                    end
                    PEND_LF:
                    begin
                        if (c == ChCr)
                        begin
                            run_calc = push_byte(run_calc, ChUnder);
                            run_calc = push_byte(run_calc, ChLf);
                        end
                        else
                        begin
                            run_calc = push_byte(run_calc, ChLf);
                            run_calc = push_byte(run_calc, c);
                        end
                    end
                    default:
                    begin
                        if (c == ChCtrlZ)
                        begin
                            fin_next = 1'b1;
                        end
                        else if (c == ChCr)
                        begin
                            pend_next = PEND_CR;
                        end
                        else if (c == ChLf)
                        begin
                            pend_next = PEND_LF;
                        end
                        else if (c != ChNul)
                        begin
                            run_calc = push_byte(run_calc, c);
                        end
                    end
                endcase
            end
        end
    end

    assign run       = run_calc;
    assign run_valid = fire && (run_calc.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            fin_reg  <= 1'b0;
        end
        else if (cfg.clear)
        begin
            pend_reg <= PEND_NONE;
            fin_reg  <= 1'b0;
        end
        else if (fire)
        begin
            pend_reg <= pend_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

[design/tle_queue.sv]
// Small queue of output runs between the classifier and the serializer.
`timescale 1ns / 1ps

module tle_queue
    import tle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output run_t head,
    output logic empty
);

    run_t             mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full  = (count_reg == QCntW'(QDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("run popped from an empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCntW'(1))
        else $error("queue count did not follow a push");

    a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_run.cnt != 2'd0)
        else $error("empty run entered the queue");
`endif

endmodule

[design/tle_back.sv]
// Serializer: sends the bytes of each queued run one per cycle while the output is ready.
`timescale 1ns / 1ps

module tle_back
    import tle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_t      head,
    input  logic      q_empty,
    output logic      pop,
    tle_out_if.source out_ch
);

    logic       busy_reg, busy_next;
    run_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       fire;
    logic       last;

    assign last = (idx_reg == cur_reg.cnt - 2'd1);
    assign fire = out_ch.valid && out_ch.ready;

    // The next run loads in the same cycle the last byte of the current one leaves.
    assign pop = !q_empty && (!busy_reg || (fire && last));

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = head;
            idx_next  = 2'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    assign out_ch.valid       = busy_reg;
    assign out_ch.out_byte    = cur_reg.data[idx_reg];
    assign out_ch.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

[tb/line_ending_checker.sv]
// Checker that predicts the converted byte stream and compares it with the output channel.
`timescale 1ns / 1ps

module line_ending_checker
    import tle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tle_in_if                   in_ch,
    tle_out_if                  out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output int                  fail_count,
    output int                  outstanding,
    output int                  bytes_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } conv_byte_t;

    conv_byte_t expected_bytes[$];

    // Shadow copy of the registers and of the conversion state.
    dir_t  cur_dir;
    mode_t cur_mode;
    pend_t held;
    logic  text_ended;

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("Mismatch at %0t: %s expected %02h, got %02h", $time, what, want, got);
    endtask

    // Works out the bytes that one input transaction produces and queues them.
    task automatic convert_item(input logic [7:0] c, input logic eoi);
        logic [7:0] run[$];
        conv_byte_t beat;
        if (cur_mode == MODE_BINARY)
        begin
            held = PEND_NONE;
            text_ended = 1'b0;
            if (!eoi)
                run.push_back(c);
        end
        else if (cur_dir == DIR_UNIX_TO_DISK)
        begin
            text_ended = 1'b0;
            if (eoi)
            begin
                if (held == PEND_UNDER)
                    run.push_back(ChUnder);
                run.push_back(ChCtrlZ);
                held = PEND_NONE;
            end
            else if (held == PEND_UNDER && c == ChLf)
            begin
                run.push_back(ChLf);
                run.push_back(ChCr);
                run.push_back(ChNul);
                held = PEND_NONE;
            end
            else
            begin
                // A held underscore not followed by LF goes out as it is.
                if (held == PEND_UNDER)
                    run.push_back(ChUnder);
                held = PEND_NONE;
                if (c == ChUnder)
                    held = PEND_UNDER;
                else if (c == ChLf)
                begin
                    run.push_back(ChCr);
                    run.push_back(ChLf);
                end
                else
                    run.push_back(c);
            end
        end
        else if (eoi)
        begin
            if (held == PEND_CR)
                run.push_back(ChCr);
            else if (held == PEND_LF)
                run.push_back(ChLf);
            held = PEND_NONE;
            text_ended = 1'b0;
        end
        else if (!text_ended)
        begin
            case (held)
                PEND_CR:
                begin
                    held = PEND_NONE;
                    if (c == ChLf)
                        run.push_back(ChLf);
                    else
                    begin
                        run.push_back(ChCr);
                        run.push_back(c);
                    end
                end
                PEND_LF:
                begin
                    held = PEND_NONE;
                    if (c == ChCr)
                    begin
                        run.push_back(ChUnder);
                        run.push_back(ChLf);
                    end
                    else
                    begin
                        run.push_back(ChLf);
                        run.push_back(c);
                    end
                end
                default:
                begin
                    held = PEND_NONE;
                    if (c == ChCtrlZ)
                        text_ended = 1'b1;
                    else if (c == ChCr)
                        held = PEND_CR;
                    else if (c == ChLf)
                        held = PEND_LF;
                    else if (c != ChNul)
                        run.push_back(c);
                end
            endcase
        end
        foreach (run[i])
        begin
            beat.data = run[i];
            beat.last = (i == run.size() - 1);
            expected_bytes.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        conv_byte_t want;
        if (!rst_n)
        begin
            cur_dir = DIR_UNIX_TO_DISK;
            cur_mode = MODE_ASCII;
            held = PEND_NONE;
            text_ended = 1'b0;
            expected_bytes.delete();
            fail_count = 0;
            outstanding = 0;
            bytes_checked = 0;
        end
        else
        begin
            // Any register write also drops a held character.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == RegDirection)
                    cur_dir = dir_t'(pwdata[0]);
                else
                    cur_mode = mode_t'(pwdata[0]);
                held = PEND_NONE;
                text_ended = 1'b0;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected output byte %02h (last %0b) at %0t",
                                 out_ch.out_byte, out_ch.last_of_run, $time);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_ch.out_byte !== want.data)
                        note_mismatch("out_byte", want.data, out_ch.out_byte);
                    if (out_ch.last_of_run !== want.last)
                        note_mismatch("last_of_run", 8'(want.last), 8'(out_ch.last_of_run));
                end
            end
            if (in_ch.valid && in_ch.ready)
                convert_item(in_ch.in_byte, in_ch.end_of_input);
            outstanding = expected_bytes.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import tle_pkg::*;

    localparam int SettleCycles = 16;
    localparam int HoldCycles   = 60;
    localparam int DrainLimit   = 20000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int outstanding;
    int bytes_checked;
    int items_sent = 0;
    int drain_misses = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int long_hold_due = 0;

    tle_in_if  in_ch ();
    tle_out_if out_ch ();

    text_line_ending_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    line_ending_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .bytes_checked (bytes_checked)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d bytes still expected", outstanding);
        $display("Some tests failed");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int holds_done;
        holds_done = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_due != holds_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                holds_done++;
            end
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic idx, input logic val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic eoi);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic end_stream();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stops sending, waits for every expected byte, then lets the block go quiet.
    task automatic settle();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        if (outstanding != 0)
            drain_misses++;
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Text-like random bytes with line endings, underscores and NULs well represented.
    task automatic send_random_text(input int count, input logic to_unix_ascii);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                end_stream();
            else if (r < 7)
            begin
                send_item(ChCtrlZ, 1'b0);
                // Ctrl-Z usually ends a to-Unix stream, so close it right away.
                if (to_unix_ascii)
                    end_stream();
            end
            else if (r < 19)
                send_item(ChLf, 1'b0);
            else if (r < 31)
                send_item(ChCr, 1'b0);
            else if (r < 41)
                send_item(ChUnder, 1'b0);
            else if (r < 46)
                send_item(ChNul, 1'b0);
            else if (r < 60)
                send_item(8'($urandom_range(0, 255)), 1'b0);
            else
                send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        end
    endtask

    initial
    begin
        int sender_idle[4];
        int receiver_stall[4];
        sender_idle = '{0, 87, 0, 16};
        receiver_stall = '{0, 0, 87, 16};
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.end_of_input = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unix to CP/M: line feeds, underscore handling and the end marker.
        write_reg(RegDirection, DIR_UNIX_TO_DISK);
        write_reg(RegTransferMode, MODE_ASCII);
        send_item(ChLf, 1'b0);
        send_item(ChUnder, 1'b0);
        send_item(ChLf, 1'b0);
        send_item(ChUnder, 1'b0);
        send_item(ChUnder, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(ChUnder, 1'b0);
        end_stream();
        end_stream();
        settle();

        // CP/M to Unix: pairs, literal bytes after a lone CR or LF, flushes and Ctrl-Z.
        write_reg(RegDirection, DIR_DISK_TO_UNIX);
        send_item(ChCr, 1'b0);
        send_item(ChLf, 1'b0);
        send_item(ChLf, 1'b0);
        send_item(ChCr, 1'b0);
        send_item(ChCr, 1'b0);
        send_item(ChNul, 1'b0);
        send_item(ChLf, 1'b0);
        send_item(ChCtrlZ, 1'b0);
        send_item(ChNul, 1'b0);
        send_item(ChCr, 1'b0);
        end_stream();
        send_item(ChLf, 1'b0);
        end_stream();
        end_stream();
        send_item(ChCtrlZ, 1'b0);
        send_item(8'h62, 1'b0);
        end_stream();
        send_item(ChCr, 1'b0);
        settle();

        // The register write drops the held CR; binary mode passes everything.
        write_reg(RegTransferMode, MODE_BINARY);
        send_item(ChCr, 1'b0);
        send_item(ChCtrlZ, 1'b0);
        end_stream();
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = sender_idle[ph];
            stall_pct <= receiver_stall[ph];
            for (int k = 0; k < 4; k++)
            begin
                settle();
                write_reg(RegDirection, k[0]);
                write_reg(RegTransferMode, k[1]);
                send_random_text(10, k == 1);
            end
        end

        // Long output hold-off while expanding line feeds keep arriving.
        settle();
        write_reg(RegDirection, DIR_UNIX_TO_DISK);
        write_reg(RegTransferMode, MODE_ASCII);
        idle_pct = 0;
        stall_pct <= 0;
        long_hold_due <= long_hold_due + 1;
        repeat (8)
        begin
            send_item(ChLf, 1'b0);
            send_item(ChUnder, 1'b0);
            send_item(ChLf, 1'b0);
        end
        end_stream();
        settle();

        $display("Covered %0d input and %0d output transactions in both directions,",
                 items_sent, bytes_checked);
        $display("ASCII and binary, with sender gaps, output stalls and a long hold-off.");
        if (fail_count == 0 && drain_misses == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
design/tle_pkg.sv
design/tle_in_if.sv
design/tle_out_if.sv
design/tle_front.sv
design/tle_queue.sv
design/tle_back.sv
design/text_line_ending_converter.sv
tb/line_ending_checker.sv
tb/testbench.sv
